FILE: hdl/gi_pkg.sv
// Shared types, constants and controller/datapath structs for the isomorphism checker.
`timescale 1ns / 1ps
package gi_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int VIDX_W = $clog2(MAX_VERTICES);      // vertex index
	localparam int VCNT_W = 4;                         // vertex count register width
	localparam int LEVEL_W = $clog2(MAX_VERTICES + 1); // Search level, holds MAX_VERTICES
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_VERTICES_A = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_VERTICES_B = 2'd1;

	typedef enum logic [1:0] {
		OP_ADD_A = 2'd0,
		OP_ADD_B = 2'd1,
		OP_CLEAR = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef logic [MAX_VERTICES-1:0] row_t;
	typedef logic [VIDX_W-1:0] vidx_t;

	// Controller to datapath
	typedef struct packed {
		logic add_a;
		logic add_b;
		logic clear;
		logic start;
		logic step;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fit;
		logic exhausted;
		logic sizes_differ;
	} dp_status_t;

endpackage

FILE: hdl/gi_if.sv
// Handshake channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps
interface gi_item_if import gi_pkg::*; ();
	logic valid;
	logic ready;
	op_t op;
	logic [2:0] edge_from;
	logic [2:0] edge_to;

	modport source(output valid, output op, output edge_from, output edge_to, input ready);
	modport sink(input valid, input op, input edge_from, input edge_to, output ready);
endinterface

interface gi_result_if;
	logic valid;
	logic ready;
	logic is_isomorphic;
	logic sizes_differ;

	modport source(output valid, output is_isomorphic, output sizes_differ, input ready);
	modport sink(input valid, input is_isomorphic, input sizes_differ, output ready);
endinterface

interface gi_cfg_if import gi_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface

FILE: hdl/graph_isomorphism_brute_force.sv
// Top level of the brute-force graph isomorphism checker.
//
//  channel  role    payload                        beat taken when
//  item     sink    op, edge_from, edge_to         valid && ready
//  result   source  is_isomorphic, sizes_differ    valid && ready
//  cfg      sink    addr (0 vertices_a, 1 b), data valid (ready always high)
//
// Edge loads and clear are taken back to back.
// A check walks vertex permutations by single swaps, one level step per cycle
// and one full 8x8 matrix compare per permutation: item ready stays low through
// the walk, which ends early on the first match or on differing vertex counts.
// The result register frees the search side; a stalled result holds the next check.
// Reset clears both matrices and the vertex counts.
`timescale 1ns / 1ps
module graph_isomorphism_brute_force import gi_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	gi_item_if.sink     item,
	gi_result_if.source result,
	gi_cfg_if.sink      cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	gi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (item.ready),
		.cfg_valid  (cfg.valid),
		.cfg_ready  (cfg.ready),
		.cfg_we     (cfg_we),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.res_iso    (result.is_isomorphic),
		.res_differ (result.sizes_differ),
		.cmd        (cmd),
		.status     (status)
	);

	gi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.edge_from (item.edge_from),
		.edge_to   (item.edge_to),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg.addr),
		.cfg_data  (cfg.data),
		.status    (status)
	);

`ifndef NO_ASSERTIONS
	// A verdict is never both a match and a size mismatch
	a_verdict_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.is_isomorphic && result.sizes_differ))
		else $error("result flags both set");

	// A check beat closes the input side for the search
	a_check_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.op == OP_CHECK) |=> !item.ready)
		else $error("input open right after check");

	// A fresh result only appears after search cycles
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result without search");

	// Search and step commands never overlap with loads
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_a, cmd.add_b, cmd.clear, cmd.start, cmd.step}))
		else $error("overlapping datapath commands");
`endif

endmodule

FILE: hdl/gi_datapath.sv
// Datapath: adjacency matrices, vertex counts, permutation walker and match logic.
`timescale 1ns / 1ps
module gi_datapath import gi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [2:0]            edge_from,
	input  logic [2:0]            edge_to,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_status_t            status
);

	row_t adj_a_q [MAX_VERTICES];
	row_t adj_b_q [MAX_VERTICES];
	vidx_t perm_q [MAX_VERTICES];
	vidx_t swap_cnt_q [MAX_VERTICES];
	logic [LEVEL_W-1:0] level_q;
	logic [VCNT_W-1:0] vert_a_q;
	logic [VCNT_W-1:0] vert_b_q;
	logic [VCNT_W-1:0] n_q;
	logic differ_q;

	logic [VCNT_W-1:0] n_sat;
	vidx_t lvl;
	vidx_t swap_idx;
	logic can_swap;
	logic mismatch;

	// Vertex count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_a_q <= '0;
			vert_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_VERTICES_A: vert_a_q <= cfg_data;
				REG_VERTICES_B: vert_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Adjacency matrices: set both symmetric bits, clear on command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_a_q[r] <= '0;
				adj_b_q[r] <= '0;
			end
		end else if (cmd.clear) begin
			for (int r = 0; r < MAX_VERTICES; r++) begin
				adj_a_q[r] <= '0;
				adj_b_q[r] <= '0;
			end
		end else if (cmd.add_a) begin
			adj_a_q[edge_from][edge_to] <= 1'b1;
			adj_a_q[edge_to][edge_from] <= 1'b1;
		end else if (cmd.add_b) begin
			adj_b_q[edge_from][edge_to] <= 1'b1;
			adj_b_q[edge_to][edge_from] <= 1'b1;
		end
	end

	// Saturate the search size
	assign n_sat = (vert_a_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vert_a_q;

	// Single-swap permutation walk: one level decision per step
	assign lvl      = level_q[VIDX_W-1:0];
	assign can_swap = swap_cnt_q[lvl] < lvl;
	assign swap_idx = level_q[0] ? swap_cnt_q[lvl] : '0;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				perm_q[k]     <= VIDX_W'(k);
				swap_cnt_q[k] <= '0;
			end
			level_q  <= LEVEL_W'(1);
			n_q      <= n_sat;
			differ_q <= vert_a_q != vert_b_q;
		end else if (cmd.step) begin
			if (can_swap) begin
				perm_q[swap_idx] <= perm_q[lvl];
				perm_q[lvl]      <= perm_q[swap_idx];
				swap_cnt_q[lvl]  <= swap_cnt_q[lvl] + 1'b1;
				level_q          <= LEVEL_W'(1);
			end else begin
				swap_cnt_q[lvl] <= '0;
				level_q         <= level_q + 1'b1;
			end
		end
	end

	// Compare every live adjacency bit of A with its mapped bit of B
	always_comb begin
		mismatch = 1'b0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			for (int j = 0; j < MAX_VERTICES; j++) begin
				if ((VCNT_W'(i) < n_q) && (VCNT_W'(j) < n_q) &&
						(adj_a_q[i][j] != adj_b_q[perm_q[i]][perm_q[j]]))
					mismatch = 1'b1;
			end
		end
	end

	assign status.fit          = !mismatch;
	assign status.exhausted    = VCNT_W'(level_q) >= n_q;
	assign status.sizes_differ = differ_q;

endmodule

FILE: hdl/gi_ctrl.sv
// Controller: handshakes, command decode, search sequencing and result register.
`timescale 1ns / 1ps
module gi_ctrl import gi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  op_t        item_op,
	output logic       item_ready,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	output logic       cfg_we,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       res_iso,
	output logic       res_differ,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	state_t state_q, state_d;
	logic pend_iso_q, pend_differ_q;
	logic pend_load;
	logic pend_iso_d, pend_differ_d;
	logic out_valid_q, out_iso_q, out_differ_q;
	logic out_load;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		item_ready    = 1'b0;
		pend_load     = 1'b0;
		pend_iso_d    = 1'b0;
		pend_differ_d = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (item_op)
						OP_ADD_A: cmd.add_a = 1'b1;
						OP_ADD_B: cmd.add_b = 1'b1;
						OP_CLEAR: cmd.clear = 1'b1;
						OP_CHECK: begin
							cmd.start = 1'b1;
							state_d   = ST_SEARCH;
						end
						default: ;
					endcase
				end
			end
			ST_SEARCH: begin
				if (status.sizes_differ) begin
					pend_load     = 1'b1;
					pend_differ_d = 1'b1;
					state_d       = ST_DONE;
				end else if (status.fit) begin
					pend_load  = 1'b1;
					pend_iso_d = 1'b1;
					state_d    = ST_DONE;
				end else if (status.exhausted) begin
					pend_load = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Latch the verdict
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_iso_q    <= pend_iso_d;
			pend_differ_q <= pend_differ_d;
		end
	end

	// Result register: drop on take, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_iso_q    <= pend_iso_q;
			out_differ_q <= pend_differ_q;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_iso    = out_iso_q;
	assign res_differ = out_differ_q;

endmodule
